[rtl/pgp_pkg.sv]
package pgp_pkg;

  localparam int CH_W        = 8;
  localparam int COLOR_W     = 24;
  localparam int SPAN_W      = 13;
  localparam int PCT_W       = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  // A dividend below 256 times the span length fits in this many bits.
  localparam int NUM_W       = CH_W + SPAN_W;
  localparam int PROD_W      = 2 * CH_W;
  localparam int LANES       = 4;
  localparam int DIV_STAGES  = CH_W;
  localparam int MAX_SPAN_DEF = 4096;

  localparam logic [CH_W-1:0]  CHAN_MAX = 8'hFF;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // floor(x / 100) for x below 43690 as a multiply and shift.
  localparam int RECIP_100_W   = 13;
  localparam int RECIP_100     = 5243;
  localparam int RECIP_SHIFT   = 19;
  localparam int SOLID_X_W     = PCT_W + CH_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_COLOR      = 3'd0,
    REG_SECOND_COLOR     = 3'd1,
    REG_SPAN_LENGTH      = 3'd2,
    REG_GRADIENT_ON      = 3'd3,
    REG_TRANSPARENT_RAMP = 3'd4,
    REG_RAMP_FLIP        = 3'd5,
    REG_ALPHA_PERCENT    = 3'd6
  } reg_idx_t;

  // Opacity of the solid fill: floor(min(percent, 100) * 255 / 100).
  function automatic logic [CH_W-1:0] solid_alpha(input logic [PCT_W-1:0] pct);
    logic [PCT_W-1:0]                         pc;
    logic [SOLID_X_W-1:0]                     x;
    logic [SOLID_X_W+RECIP_100_W-1:0]         prod;
    pc   = (pct > PCT_FULL) ? PCT_FULL : pct;
    x    = (SOLID_X_W'(pc) << CH_W) - SOLID_X_W'(pc);
    prod = (SOLID_X_W+RECIP_100_W)'(x) * (SOLID_X_W+RECIP_100_W)'(RECIP_100);
    return prod[RECIP_SHIFT +: CH_W];
  endfunction

  // floor(x / 255) for any 16-bit product of two bytes.
  function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] t;
    t = (PROD_W+1)'(x) + (PROD_W+1)'(x >> CH_W) + (PROD_W+1)'(1);
    return t[CH_W +: CH_W];
  endfunction

endpackage

[rtl/premultiplied_gradient_pixel_core.sv]
// Linear gradient fill with premultiplied alpha, one pixel per transaction.
// The input channel carries a pixel position along the span; the output
// channel returns the alpha byte and the red, green and blue bytes already
// multiplied by alpha / 255. Positions beyond the span length saturate.
// Configuration registers are written through the cfg_ port (write enable,
// index, data) while no transactions are in flight; writes to an unused
// index are dropped.
// The pipeline is twelve register stages deep, and a new position is
// accepted every cycle while in_stall is low. The depth is set by the
// division by the span length, which resolves one quotient bit per
// stage over eight stages.
// Synchronous active-low reset empties the pipeline and loads the register
// defaults (span length 1, solid fill at 100 percent, black colors).
// When the receiver holds out_stall while a result is waiting, the whole
// pipeline freezes and in_stall is raised in the same cycle, so nothing is
// dropped or repeated.
module premultiplied_gradient_pixel_core #(
  parameter int MAX_SPAN = pgp_pkg::MAX_SPAN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pgp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pgp_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pgp_pkg::SPAN_W-1:0]          in_position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pgp_pkg::CH_W-1:0]            out_alpha_out,
  output logic [pgp_pkg::CH_W-1:0]            out_red_out,
  output logic [pgp_pkg::CH_W-1:0]            out_green_out,
  output logic [pgp_pkg::CH_W-1:0]            out_blue_out
);
  import pgp_pkg::*;

  logic [COLOR_W-1:0] first_color_r;
  logic [COLOR_W-1:0] second_color_r;
  logic [SPAN_W-1:0]  span_length_r;
  logic               gradient_on_r;
  logic               transparent_ramp_r;
  logic               ramp_flip_r;
  logic [PCT_W-1:0]   alpha_percent_r;
  logic [CH_W-1:0]    solid_alpha_r;

  logic adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_color_r      <= '0;
      second_color_r     <= '0;
      span_length_r      <= SPAN_W'(1);
      gradient_on_r      <= 1'b0;
      transparent_ramp_r <= 1'b0;
      ramp_flip_r        <= 1'b0;
      alpha_percent_r    <= PCT_FULL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_COLOR:      first_color_r      <= cfg_data[COLOR_W-1:0];
        REG_SECOND_COLOR:     second_color_r     <= cfg_data[COLOR_W-1:0];
        REG_SPAN_LENGTH:      span_length_r      <= cfg_data[SPAN_W-1:0];
        REG_GRADIENT_ON:      gradient_on_r      <= cfg_data[0];
        REG_TRANSPARENT_RAMP: transparent_ramp_r <= cfg_data[0];
        REG_RAMP_FLIP:        ramp_flip_r        <= cfg_data[0];
        REG_ALPHA_PERCENT:    alpha_percent_r    <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived from a register, so it settles long before any transaction reaches
  // the stage that uses it.
  always_ff @(posedge clk) begin
    solid_alpha_r <= solid_alpha(alpha_percent_r);
  end

  logic out_valid_r;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Stage A: effective length, clamped position and ramp weights.
  logic [SPAN_W-1:0] len_eff;
  logic [SPAN_W-1:0] pos_sat;
  logic [SPAN_W-1:0] w1;
  logic              vld_a_r;
  logic [SPAN_W-1:0] len_a_r;
  logic [SPAN_W-1:0] pos_a_r;
  logic [SPAN_W-1:0] w1_a_r;
  logic [SPAN_W-1:0] w2_a_r;

  always_comb begin
    if (span_length_r == '0) begin
      len_eff = SPAN_W'(1);
    end else if (32'(span_length_r) > 32'(MAX_SPAN)) begin
      len_eff = SPAN_W'(MAX_SPAN);
    end else begin
      len_eff = span_length_r;
    end
    pos_sat = (in_position > len_eff) ? len_eff : in_position;
    w1      = ramp_flip_r ? (len_eff - pos_sat) : pos_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (adv) begin
      vld_a_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      len_a_r <= len_eff;
      pos_a_r <= pos_sat;
      w1_a_r  <= w1;
      w2_a_r  <= len_eff - w1;
    end
  end

  // Stage B writes the dividends into the first slot of the divider arrays.
  // Lane 0 is the alpha ramp, lanes 1 to 3 are red, green and blue.
  logic [NUM_W-1:0]  rem_r [DIV_STAGES][LANES];
  logic [SPAN_W-1:0] len_r [DIV_STAGES];
  logic [CH_W-1:0]   quo_r [1:DIV_STAGES][LANES];
  logic              vld_r [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      len_r[0]    <= len_a_r;
      rem_r[0][0] <= (NUM_W'(pos_a_r) << CH_W) - NUM_W'(pos_a_r);
      for (int k = 0; k < LANES - 1; k++) begin
        rem_r[0][k+1] <=
          NUM_W'(first_color_r[COLOR_W-1-CH_W*k -: CH_W]) * NUM_W'(w1_a_r) +
          NUM_W'(second_color_r[COLOR_W-1-CH_W*k -: CH_W]) * NUM_W'(w2_a_r);
      end
    end
  end

  // Restoring division by the span length, one quotient bit per stage.
  for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
    localparam int Sh = DIV_STAGES - 1 - d;
    logic [NUM_W-1:0] trial;
    logic [CH_W-1:0]  q_prev [LANES];
    logic             take   [LANES];

    assign trial = NUM_W'(len_r[d]) << Sh;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      if (d == 0) begin : g_first
        assign q_prev[l] = '0;
      end else begin : g_next
        assign q_prev[l] = quo_r[d][l];
      end
      assign take[l] = (rem_r[d][l] >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[d+1] <= 1'b0;
      end else if (adv) begin
        vld_r[d+1] <= vld_r[d];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int l = 0; l < LANES; l++) begin
          quo_r[d+1][l] <= q_prev[l] | (take[l] ? (CH_W'(1) << Sh) : '0);
        end
      end
    end

    if (d < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          len_r[d+1] <= len_r[d];
          for (int l = 0; l < LANES; l++) begin
            rem_r[d+1][l] <= take[l] ? (rem_r[d][l] - trial) : rem_r[d][l];
          end
        end
      end
    end
  end

  // Stage P: choose alpha and color by mode, then multiply.
  logic [CH_W-1:0]   alpha_sel;
  logic [CH_W-1:0]   color_sel [LANES-1];
  logic              vld_p_r;
  logic [CH_W-1:0]   alpha_p_r;
  logic [PROD_W-1:0] prod_r [LANES-1];

  always_comb begin
    priority if (!gradient_on_r) begin
      alpha_sel = solid_alpha_r;
    end else if (transparent_ramp_r) begin
      alpha_sel = ramp_flip_r ? (CHAN_MAX - quo_r[DIV_STAGES][0]) : quo_r[DIV_STAGES][0];
    end else begin
      alpha_sel = CHAN_MAX;
    end
    for (int k = 0; k < LANES - 1; k++) begin
      if (gradient_on_r && !transparent_ramp_r) begin
        color_sel[k] = quo_r[DIV_STAGES][k+1];
      end else begin
        color_sel[k] = first_color_r[COLOR_W-1-CH_W*k -: CH_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_p_r <= 1'b0;
    end else if (adv) begin
      vld_p_r <= vld_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      alpha_p_r <= alpha_sel;
      for (int k = 0; k < LANES - 1; k++) begin
        prod_r[k] <= PROD_W'(color_sel[k]) * PROD_W'(alpha_sel);
      end
    end
  end

  // Output register: divide the products by 255.
  logic [CH_W-1:0] alpha_out_r;
  logic [CH_W-1:0] red_out_r;
  logic [CH_W-1:0] green_out_r;
  logic [CH_W-1:0] blue_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      alpha_out_r <= alpha_p_r;
      red_out_r   <= div255(prod_r[0]);
      green_out_r <= div255(prod_r[1]);
      blue_out_r  <= div255(prod_r[2]);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_alpha_out = alpha_out_r;
  assign out_red_out   = red_out_r;
  assign out_green_out = green_out_r;
  assign out_blue_out  = blue_out_r;

endmodule
